>>> hw/rtl/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int WORD_BITS   = 32;
    localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam int REQ_BITS    = 3;
    localparam int STATUS_BITS = 2;
    localparam int READ_BITS   = 32;
    localparam int HELD_BITS   = 7;

    localparam logic [REQ_BITS-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_PEEK_FRONT = 3'd4;
    localparam logic [REQ_BITS-1:0] REQ_PEEK_BACK  = 3'd5;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR      = 3'd6;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_WORD  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd3;

    typedef logic [IDX_BITS-1:0] idx_t;
    typedef logic [CNT_BITS-1:0] cnt_t;

    // Result waiting for its read data from the ring memory.
    typedef struct packed {
        logic                   valid;
        logic [STATUS_BITS-1:0] status;
        cnt_t                   held;
    } pend_t;

    // Ring position that lies offset words after base; offset never exceeds the depth.
    function automatic idx_t slot_after(idx_t base, cnt_t offset);
        logic [CNT_BITS:0] sum;
        sum = (CNT_BITS + 1)'(base) + (CNT_BITS + 1)'(offset);
        if (sum >= (CNT_BITS + 1)'(QUEUE_DEPTH))
        begin
            sum = sum - (CNT_BITS + 1)'(QUEUE_DEPTH);
        end
        return IDX_BITS'(sum);
    endfunction

    function automatic idx_t slot_before(idx_t base);
        idx_t prev;
        if (base == '0)
        begin
            prev = IDX_BITS'(QUEUE_DEPTH - 1);
        end
        else
        begin
            prev = base - idx_t'(1);
        end
        return prev;
    endfunction

endpackage

>>> hw/rtl/deq_ram.sv
`timescale 1ns / 1ps

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/double_ended_queue_top.sv
`timescale 1ns / 1ps
// Path: an accepted request passes the pending stage, where the ring memory read data
// arrives, then the output register; an output stall holds it in the pending stage.
// Throughput: one request per cycle while results are taken; the ring memory has one
// write and one registered read port, and each request uses at most one of them.
// Reset: rst_n clears the front pointer, the word count and all valid flags; the ring
// memory contents are not cleared, and no clearing pass is needed.
module double_ended_queue_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [deq_pkg::REQ_BITS-1:0]   req_type,
    input  logic [31:0]                    push_word,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [deq_pkg::STATUS_BITS-1:0] status,
    output logic [deq_pkg::READ_BITS-1:0]  read_word,
    output logic [deq_pkg::HELD_BITS-1:0]  entries_held
);
    import deq_pkg::*;

    idx_t  front_reg, front_next;
    cnt_t  count_reg, count_next;
    pend_t pend_reg, pend_next;

    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_BITS-1:0] out_status_reg, out_status_next;
    logic [READ_BITS-1:0]   out_word_reg, out_word_next;
    cnt_t                   out_held_reg, out_held_next;

    logic                   accept;
    logic                   out_load;
    logic                   mem_we;
    logic                   mem_re;
    idx_t                   mem_waddr;
    idx_t                   mem_raddr;
    logic [WORD_BITS-1:0]   mem_rdata;
    logic [STATUS_BITS-1:0] req_status;
    logic                   is_empty;
    logic                   is_full;

    // The pending stage drains into the output register whenever that register is free.
    assign out_load = pend_reg.valid && (!out_valid_reg || out_ready);
    assign in_ready = !pend_reg.valid || !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_BITS'(QUEUE_DEPTH));

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = front_reg;
        mem_raddr  = front_reg;
        req_status = ST_OK;
        if (accept)
        begin
            unique case (req_type) inside
                REQ_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        req_status = ST_FULL;
                    end
                    else
                    begin
                        front_next = slot_before(front_reg);
                        mem_waddr  = slot_before(front_reg);
                        mem_we     = 1'b1;
                        count_next = count_reg + cnt_t'(1);
                    end
                end
                REQ_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        req_status = ST_FULL;
                    end
                    else
                    begin
                        mem_waddr  = slot_after(front_reg, count_reg);
                        mem_we     = 1'b1;
                        count_next = count_reg + cnt_t'(1);
                    end
                end
                REQ_POP_FRONT, REQ_PEEK_FRONT:
                begin
                    if (is_empty)
                    begin
                        req_status = ST_EMPTY;
                    end
                    else
                    begin
                        req_status = ST_WORD;
                        mem_re     = 1'b1;
                        mem_raddr  = front_reg;
                        if (req_type == REQ_POP_FRONT)
                        begin
                            front_next = slot_after(front_reg, cnt_t'(1));
                            count_next = count_reg - cnt_t'(1);
                        end
                    end
                end
                REQ_POP_BACK, REQ_PEEK_BACK:
                begin
                    if (is_empty)
                    begin
                        req_status = ST_EMPTY;
                    end
                    else
                    begin
                        req_status = ST_WORD;
                        mem_re     = 1'b1;
                        mem_raddr  = slot_after(front_reg, count_reg - cnt_t'(1));
                        if (req_type == REQ_POP_BACK)
                        begin
                            count_next = count_reg - cnt_t'(1);
                        end
                    end
                end
                REQ_CLEAR:
                begin
                    front_next = '0;
                    count_next = '0;
                end
                default:
                begin
                    req_status = ST_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (accept)
        begin
            pend_next.valid  = 1'b1;
            pend_next.status = req_status;
            pend_next.held   = count_next;
        end
        else if (out_load)
        begin
            pend_next.valid = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_word_next   = out_word_reg;
        out_held_next   = out_held_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = pend_reg.status;
            out_held_next   = pend_reg.held;
            if (pend_reg.status == ST_WORD)
            begin
                out_word_next = READ_BITS'(mem_rdata);
            end
            else
            begin
                out_word_next = '0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg      <= '0;
            count_reg      <= '0;
            pend_reg.valid <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_word_reg   <= out_word_next;
        out_held_reg   <= out_held_next;
    end

    deq_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (WORD_BITS'(push_word)),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign read_word    = out_word_reg;
    assign entries_held = HELD_BITS'(out_held_reg);

endmodule

>>> hw/rtl/deq_checker.sv
`timescale 1ns / 1ps

module deq_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [deq_pkg::STATUS_BITS-1:0] status,
    input logic [deq_pkg::READ_BITS-1:0]   read_word,
    input logic [deq_pkg::HELD_BITS-1:0]   entries_held
);
    import deq_pkg::*;

    // A word waiting at the output must not vanish before it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_WORD |-> read_word == '0)
        else $error("read_word nonzero without a returned word");

    a_empty_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> entries_held == '0)
        else $error("empty error reported with words held");

    a_full_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> entries_held == HELD_BITS'(QUEUE_DEPTH))
        else $error("full error reported on a queue that is not full");

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entries_held <= HELD_BITS'(QUEUE_DEPTH))
        else $error("entries_held beyond queue depth");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (.*);
